// File: rtl/isg_pkg.sv
// ----------------------------------------------------------------------------
// Ising site update package
// Shared constants, action codes and register indexes for the Ising
// Metropolis site update block and its lattice RAM.
// ----------------------------------------------------------------------------
package isg_pkg;

   // Lattice geometry (power-of-two maxima, site index is {row, col})
   localparam int MAX_WIDTH     = 64;
   localparam int MAX_HEIGHT    = 64;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int SITE_BITS     = COL_BITS + ROW_BITS;
   localparam int LATTICE_SITES = MAX_WIDTH * MAX_HEIGHT;

   // Size registers hold 0..127, wide enough for 0..MAX inclusive
   localparam int SIZE_BITS     = 7;

   // Random fraction and thresholds
   localparam int FRACTION_BITS = 16;
   localparam logic [FRACTION_BITS-1:0] HALF_FRACTION = FRACTION_BITS'(1) << (FRACTION_BITS - 1);

   // Reset values of the configuration registers
   localparam logic [SIZE_BITS-1:0]     WIDTH_RESET   = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0]     HEIGHT_RESET  = SIZE_BITS'(MAX_HEIGHT);
   localparam logic [FRACTION_BITS-1:0] THRESH4_RESET = FRACTION_BITS'(11239);
   localparam logic [FRACTION_BITS-1:0] THRESH8_RESET = FRACTION_BITS'(1928);

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH   = 2'd0,
      CSR_HEIGHT  = 2'd1,
      CSR_THRESH4 = 2'd2,
      CSR_THRESH8 = 2'd3
   } csr_index_type;

   // Item actions; the remaining code has no meaning
   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_READ   = 2'd1,
      ACT_UPDATE = 2'd2
   } action_type;

   localparam int COUNT_BITS = 3;

endpackage

// File: rtl/isg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read. A read
// and a write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module isg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ising_metropolis_site_update.sv
// ----------------------------------------------------------------------------
// Ising Metropolis site update
// Binary spin lattice on a torus with load, read and Metropolis update items.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, as long as the result side keeps taking items;
// results pass the item register, then the result register. The five lattice
// bits an update needs (site and four wrapped neighbours) come from five
// copies of a 4096 x 1 RAM, each read at one address per cycle and all
// written together, so five reads and one write fit in every cycle. A site
// written by the item just ahead is forwarded past the RAM. The lattice is not
// cleared at reset: a site must be loaded before it is read or used as a
// neighbour. Configuration writes are always taken at once and must only be
// issued while no item is in flight.
module ising_metropolis_site_update (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [isg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [isg_pkg::CSR_DATA_BITS-1:0]     csr_data,
   // items in
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [isg_pkg::COL_BITS-1:0]          req_col,
   input  logic [isg_pkg::ROW_BITS-1:0]          req_row,
   input  logic                                  req_pixel_in,
   input  logic [isg_pkg::FRACTION_BITS-1:0]     req_random_fraction,
   // results out
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_pixel_out,
   output logic [isg_pkg::COUNT_BITS-1:0]        rsp_neighbour_count,
   output logic                                  rsp_flipped,
   output logic                                  rsp_coord_error
);

   import isg_pkg::*;

   localparam int TAPS = 5;   // centre, left, right, up, down
   localparam int TAP_C = 0;
   localparam int TAP_L = 1;
   localparam int TAP_R = 2;
   localparam int TAP_U = 3;
   localparam int TAP_D = 4;

   // ---------------------------------------------------------------- config
   logic [SIZE_BITS-1:0]     width_ff;
   logic [SIZE_BITS-1:0]     height_ff;
   logic [FRACTION_BITS-1:0] thresh4_ff;
   logic [FRACTION_BITS-1:0] thresh8_ff;

   assign csr_ready = 1'b1;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         thresh4_ff <= THRESH4_RESET;
         thresh8_ff <= THRESH8_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:   width_ff   <= csr_data[SIZE_BITS-1:0];
            CSR_HEIGHT:  height_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_THRESH4: thresh4_ff <= csr_data[FRACTION_BITS-1:0];
            CSR_THRESH8: thresh8_ff <= csr_data[FRACTION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------ stage 0: address build
   logic [SIZE_BITS-1:0] w_use;
   logic [SIZE_BITS-1:0] h_use;
   logic [SIZE_BITS-1:0] w_less1;
   logic [SIZE_BITS-1:0] h_less1;
   logic [SIZE_BITS-1:0] col_plus1;
   logic [SIZE_BITS-1:0] row_plus1;
   logic [COL_BITS-1:0]  col_left;
   logic [COL_BITS-1:0]  col_right;
   logic [ROW_BITS-1:0]  row_up;
   logic [ROW_BITS-1:0]  row_down;
   logic                 coord_err_in;
   logic [SITE_BITS-1:0] addr_in [TAPS];
   logic                 req_accept;

   // Saturate the sizes and wrap the neighbour coordinates
   always_comb begin
      w_use     = (width_ff  > SIZE_BITS'(MAX_WIDTH))  ? SIZE_BITS'(MAX_WIDTH)  : width_ff;
      h_use     = (height_ff > SIZE_BITS'(MAX_HEIGHT)) ? SIZE_BITS'(MAX_HEIGHT) : height_ff;
      w_less1   = w_use - SIZE_BITS'(1);
      h_less1   = h_use - SIZE_BITS'(1);
      col_plus1 = SIZE_BITS'(req_col) + SIZE_BITS'(1);
      row_plus1 = SIZE_BITS'(req_row) + SIZE_BITS'(1);

      col_left  = (req_col != '0) ? req_col - COL_BITS'(1) : w_less1[COL_BITS-1:0];
      col_right = (col_plus1 < w_use) ? col_plus1[COL_BITS-1:0] : '0;
      row_up    = (req_row != '0) ? req_row - ROW_BITS'(1) : h_less1[ROW_BITS-1:0];
      row_down  = (row_plus1 < h_use) ? row_plus1[ROW_BITS-1:0] : '0;

      coord_err_in = (SIZE_BITS'(req_col) >= w_use) || (SIZE_BITS'(req_row) >= h_use);

      addr_in[TAP_C] = {req_row,  req_col};
      addr_in[TAP_L] = {req_row,  col_left};
      addr_in[TAP_R] = {req_row,  col_right};
      addr_in[TAP_U] = {row_up,   req_col};
      addr_in[TAP_D] = {row_down, req_col};
   end

   // ------------------------------------------------------ lattice storage
   logic                 s1_valid_ff;
   logic                 s1_advance;
   logic                 lat_wr_en;
   logic [SITE_BITS-1:0] lat_wr_addr;
   logic                 lat_wr_data;
   logic                 rd_bit [TAPS];

   for (genvar t = 0; t < TAPS; t++) begin : g_copy
      isg_ram #(
         .WIDTH (1),
         .DEPTH (LATTICE_SITES)
      ) u_lattice (
         .clock   (clock),
         .wr_en   (lat_wr_en),
         .wr_addr (lat_wr_addr),
         .wr_data (lat_wr_data),
         .rd_en   (req_accept),
         .rd_addr (addr_in[t]),
         .rd_data (rd_bit[t])
      );
   end

   // ------------------------------------------------ stage 1: item register
   logic [1:0]               s1_action_ff;
   logic                     s1_err_ff;
   logic                     s1_pixel_ff;
   logic [FRACTION_BITS-1:0] s1_frac_ff;
   logic [SITE_BITS-1:0]     s1_addr_ff [TAPS];
   logic                     rsp_valid_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // Hold the valid flag while the result side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Capture the item alongside its RAM reads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_err_ff    <= coord_err_in;
         s1_pixel_ff  <= req_pixel_in;
         s1_frac_ff   <= req_random_fraction;
         for (int t = 0; t < TAPS; t++) begin
            s1_addr_ff[t] <= addr_in[t];
         end
      end
   end

   // Last lattice write, forwarded past the read-old RAM
   logic                 fwd_valid_ff;
   logic [SITE_BITS-1:0] fwd_addr_ff;
   logic                 fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (lat_wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lat_wr_en) begin
         fwd_addr_ff <= lat_wr_addr;
         fwd_data_ff <= lat_wr_data;
      end
   end

   // ------------------------------------------------ stage 1: site rule
   logic                  site_bit [TAPS];
   logic [COUNT_BITS-1:0] count;
   logic                  old_bit;
   logic                  new_bit;
   logic                  below4;
   logic                  below8;
   logic                  pixel_in;
   logic [COUNT_BITS-1:0] count_in;
   logic                  flipped_in;
   logic                  cerr_in;

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         site_bit[t] = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff[t])) ? fwd_data_ff
                                                                         : rd_bit[t];
      end
      old_bit = site_bit[TAP_C];
      count   = COUNT_BITS'(site_bit[TAP_L]) + COUNT_BITS'(site_bit[TAP_R])
              + COUNT_BITS'(site_bit[TAP_U]) + COUNT_BITS'(site_bit[TAP_D]);
      below4  = s1_frac_ff < thresh4_ff;
      below8  = s1_frac_ff < thresh8_ff;

      // Metropolis rule
      if (count > COUNT_BITS'(2)) begin
         if (!old_bit) begin
            new_bit = 1'b1;
         end else begin
            new_bit = !((count == COUNT_BITS'(3) && below4) ||
                        (count == COUNT_BITS'(4) && below8));
         end
      end else if (count == COUNT_BITS'(2)) begin
         new_bit = !(s1_frac_ff < HALF_FRACTION);
      end else if (old_bit) begin
         new_bit = 1'b0;
      end else begin
         new_bit = (count == COUNT_BITS'(1) && below4) ||
                   (count == COUNT_BITS'(0) && below8);
      end

      // Result and lattice write per action
      pixel_in    = 1'b0;
      count_in    = '0;
      flipped_in  = 1'b0;
      cerr_in     = 1'b0;
      lat_wr_en   = 1'b0;
      lat_wr_data = 1'b0;
      case (s1_action_ff)
         ACT_LOAD: begin
            cerr_in     = s1_err_ff;
            pixel_in    = !s1_err_ff && s1_pixel_ff;
            lat_wr_en   = s1_advance && !s1_err_ff;
            lat_wr_data = s1_pixel_ff;
         end
         ACT_READ: begin
            cerr_in  = s1_err_ff;
            pixel_in = !s1_err_ff && old_bit;
         end
         ACT_UPDATE: begin
            cerr_in     = s1_err_ff;
            pixel_in    = !s1_err_ff && new_bit;
            count_in    = s1_err_ff ? '0 : count;
            flipped_in  = !s1_err_ff && (new_bit != old_bit);
            lat_wr_en   = s1_advance && !s1_err_ff;
            lat_wr_data = new_bit;
         end
         default: ;
      endcase
      lat_wr_addr = s1_addr_ff[TAP_C];
   end

   // ------------------------------------------------------ result register
   logic                  rsp_pixel_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_flipped_ff;
   logic                  rsp_cerr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_pixel_ff   <= pixel_in;
         rsp_count_ff   <= count_in;
         rsp_flipped_ff <= flipped_in;
         rsp_cerr_ff    <= cerr_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_out       = rsp_pixel_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_flipped         = rsp_flipped_ff;
   assign rsp_coord_error     = rsp_cerr_ff;

   // ------------------------------------------------------------ assertions
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("stalled item dropped from stage 1");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      lat_wr_en |-> s1_valid_ff && s1_advance && !s1_err_ff)
      else $error("lattice written without an advancing in-range item");

   a_error_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coord_error |->
         !rsp_pixel_out && !rsp_flipped && rsp_neighbour_count == '0)
      else $error("flagged result carries site data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_neighbour_count <= COUNT_BITS'(4))
      else $error("neighbour count above four");

endmodule

// File: tb/ising_metropolis_site_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising Metropolis site update testbench
// Streams load, read and update items through the lattice block under a run
// of lattice sizes and thresholds, and predicts every result from a local copy
// of the spin lattice. Reads and updates only touch sites already loaded.
// Both handshakes stall at random in two idling modes; a third never idles.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_tb;
   import isg_pkg::*;

   // The code left over by the action enum
   localparam logic [1:0] ACT_NONE      = 2'd3;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         RANDOM_PHASES = 9;
   localparam int         PHASE_ITEMS   = 178;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         REPORT_LIMIT  = 10;

   typedef struct {
      logic [1:0]               action;
      logic [COL_BITS-1:0]      col;
      logic [ROW_BITS-1:0]      row;
      logic                     pixel_in;
      logic [FRACTION_BITS-1:0] fraction;
   } site_item_type;

   typedef struct {
      logic                  pixel_out;
      logic [COUNT_BITS-1:0] count;
      logic                  flipped;
      logic                  coord_error;
   } site_result_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action = '0;
   logic [COL_BITS-1:0]       req_col = '0;
   logic [ROW_BITS-1:0]       req_row = '0;
   logic                      req_pixel_in = 1'b0;
   logic [FRACTION_BITS-1:0]  req_random_fraction = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_pixel_out;
   logic [COUNT_BITS-1:0]     rsp_neighbour_count;
   logic                      rsp_flipped;
   logic                      rsp_coord_error;

   // Local copy of the registers, the spins and which sites hold a value
   logic [SIZE_BITS-1:0]      width_reg   = WIDTH_RESET;
   logic [SIZE_BITS-1:0]      height_reg  = HEIGHT_RESET;
   logic [FRACTION_BITS-1:0]  thresh4_reg = THRESH4_RESET;
   logic [FRACTION_BITS-1:0]  thresh8_reg = THRESH8_RESET;
   bit                        spin_copy [LATTICE_SITES];
   bit                        site_loaded [LATTICE_SITES];

   site_item_type             pending_items [$];
   site_result_type           expected_results [$];
   site_item_type             item_on_port;
   int                        send_idle_pct = 35;
   int                        recv_idle_pct = 48;
   int                        mismatches = 0;
   int                        result_count = 0;
   int                        cycle_count = 0;

   ising_metropolis_site_update u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_col             (req_col),
      .req_row             (req_row),
      .req_pixel_in        (req_pixel_in),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_neighbour_count (rsp_neighbour_count),
      .rsp_flipped         (rsp_flipped),
      .rsp_coord_error     (rsp_coord_error)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int size_in_use(logic [SIZE_BITS-1:0] raw, int limit);
      return (int'(raw) > limit) ? limit : int'(raw);
   endfunction

   function automatic int site_index(int x, int y);
      return y * MAX_WIDTH + x;
   endfunction

   // Metropolis site update on the local lattice; returns the result of one item
   function automatic site_result_type apply_site_item(site_item_type it);
      site_result_type r;
      int              w, h, x, y, xl, xr, yu, yd, n;
      bit              old_spin, new_spin, below4, below8;
      r = '{default: 0};
      w = size_in_use(width_reg, MAX_WIDTH);
      h = size_in_use(height_reg, MAX_HEIGHT);
      x = it.col;
      y = it.row;
      if (it.action == ACT_NONE)
         return r;
      if (x >= w || y >= h) begin
         r.coord_error = 1'b1;
         return r;
      end
      case (it.action)
         ACT_LOAD: begin
            spin_copy[site_index(x, y)] = it.pixel_in;
            r.pixel_out = it.pixel_in;
         end
         ACT_READ: begin
            r.pixel_out = spin_copy[site_index(x, y)];
         end
         default: begin
            xl = (x > 0) ? x - 1 : w - 1;
            xr = (x + 1 < w) ? x + 1 : 0;
            yu = (y > 0) ? y - 1 : h - 1;
            yd = (y + 1 < h) ? y + 1 : 0;
            n = spin_copy[site_index(xl, y)] + spin_copy[site_index(xr, y)]
              + spin_copy[site_index(x, yu)] + spin_copy[site_index(x, yd)];
            old_spin = spin_copy[site_index(x, y)];
            below4 = it.fraction < thresh4_reg;
            below8 = it.fraction < thresh8_reg;
            new_spin = old_spin;
            if (n > 2) begin
               if (!old_spin)
                  new_spin = 1'b1;
               else if ((n == 3 && below4) || (n == 4 && below8))
                  new_spin = 1'b0;
            end else if (n == 2) begin
               new_spin = (it.fraction < HALF_FRACTION) ? 1'b0 : 1'b1;
            end else begin
               if (old_spin)
                  new_spin = 1'b0;
               else if ((n == 1 && below4) || (n == 0 && below8))
                  new_spin = 1'b1;
            end
            spin_copy[site_index(x, y)] = new_spin;
            r.pixel_out = new_spin;
            r.count = COUNT_BITS'(n);
            r.flipped = new_spin != old_spin;
         end
      endcase
      return r;
   endfunction

   // Queue one item and note the site it loads, if any
   function automatic void queue_item(logic [1:0] action, int col, int row, logic pixel,
                                      logic [FRACTION_BITS-1:0] fraction);
      site_item_type it;
      it.action = action;
      it.col = COL_BITS'(col);
      it.row = ROW_BITS'(row);
      it.pixel_in = pixel;
      it.fraction = fraction;
      if (action == ACT_LOAD && col < size_in_use(width_reg, MAX_WIDTH)
          && row < size_in_use(height_reg, MAX_HEIGHT))
         site_loaded[site_index(col, row)] = 1'b1;
      pending_items.push_back(it);
   endfunction

   // Favour the edges so that the wrap is exercised often
   function automatic int pick_coord(int limit);
      int c;
      case ($urandom_range(0, 3))
         0: c = 0;
         1: c = limit - 1;
         2: c = $urandom_range(0, 1) ? 1 : limit - 2;
         default: c = $urandom_range(0, limit - 1);
      endcase
      if (c < 0)
         c = 0;
      if (c >= limit)
         c = limit - 1;
      return c;
   endfunction

   // Random fraction, often right at a threshold or at one half
   function automatic logic [FRACTION_BITS-1:0] pick_fraction();
      int f;
      case ($urandom_range(0, 7))
         0: f = int'(thresh4_reg) + int'($urandom_range(0, 2)) - 1;
         1: f = int'(thresh8_reg) + int'($urandom_range(0, 2)) - 1;
         2: f = int'(HALF_FRACTION) - int'($urandom_range(0, 1));
         3: f = $urandom_range(0, 1) ? 0 : 65535;
         default: f = $urandom_range(0, 65535);
      endcase
      if (f < 0)
         f = 0;
      if (f > 65535)
         f = 65535;
      return FRACTION_BITS'(f);
   endfunction

   // One random item; a read or update of an unloaded site turns into a load of the first unloaded site it needs
   function automatic void queue_random_item();
      int         w, h, x, y, roll, miss, needed;
      int         nx [5];
      int         ny [5];
      logic [1:0] action;
      w = size_in_use(width_reg, MAX_WIDTH);
      h = size_in_use(height_reg, MAX_HEIGHT);
      roll = $urandom_range(0, 99);
      x = pick_coord(w);
      y = pick_coord(h);
      case ($urandom_range(0, 2))
         0: action = ACT_LOAD;
         1: action = ACT_READ;
         default: action = ACT_UPDATE;
      endcase
      if (roll < 4) begin
         queue_item(ACT_NONE, $urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                    1'($urandom_range(0, 1)), pick_fraction());
         return;
      end
      // out-of-range coordinates only exist when the full lattice is not in use
      if (roll < 14 && (w < MAX_WIDTH || h < MAX_HEIGHT)) begin
         if (w < MAX_WIDTH && ($urandom_range(0, 1) || h == MAX_HEIGHT))
            x = $urandom_range(w, MAX_WIDTH - 1);
         else
            y = $urandom_range(h, MAX_HEIGHT - 1);
         queue_item(action, x, y, 1'($urandom_range(0, 1)), pick_fraction());
         return;
      end
      if (roll < 34)
         action = ACT_LOAD;
      else if (roll < 50)
         action = ACT_READ;
      else
         action = ACT_UPDATE;
      nx[0] = x;                       ny[0] = y;
      nx[1] = (x > 0) ? x - 1 : w - 1; ny[1] = y;
      nx[2] = (x + 1 < w) ? x + 1 : 0; ny[2] = y;
      nx[3] = x;                       ny[3] = (y > 0) ? y - 1 : h - 1;
      nx[4] = x;                       ny[4] = (y + 1 < h) ? y + 1 : 0;
      needed = (action == ACT_UPDATE) ? 5 : (action == ACT_READ) ? 1 : 0;
      miss = -1;
      for (int k = 0; k < needed; k++)
         if (miss < 0 && !site_loaded[site_index(nx[k], ny[k])])
            miss = k;
      if (miss >= 0)
         queue_item(ACT_LOAD, nx[miss], ny[miss], 1'($urandom_range(0, 1)), pick_fraction());
      else
         queue_item(action, x, y, 1'($urandom_range(0, 1)), pick_fraction());
   endfunction

   function automatic bit count_failure();
      mismatches++;
      return mismatches <= REPORT_LIMIT;
   endfunction

   // Hold until every queued item has been sent and answered
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type index, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DATA_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_WIDTH:   width_reg   = SIZE_BITS'(value);
         CSR_HEIGHT:  height_reg  = SIZE_BITS'(value);
         CSR_THRESH4: thresh4_reg = FRACTION_BITS'(value);
         default:     thresh8_reg = FRACTION_BITS'(value);
      endcase
   endtask

   // Drain, then write all four registers; size writes carry junk above bit 6
   task automatic configure(int width, int height, int thresh4, int thresh8);
      wait_idle();
      write_reg(CSR_WIDTH, (int'($urandom_range(0, 511)) << SIZE_BITS) | width);
      write_reg(CSR_HEIGHT, (int'($urandom_range(0, 511)) << SIZE_BITS) | height);
      write_reg(CSR_THRESH4, thresh4);
      write_reg(CSR_THRESH8, thresh8);
   endtask

   // Stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes: far corners, reads back, the unused action code
      queue_item(ACT_LOAD, 63, 63, 1'b1, 16'hFFFF);
      queue_item(ACT_LOAD, 0, 0, 1'b0, 16'h0000);
      queue_item(ACT_READ, 63, 63, 1'b0, 16'h0000);
      queue_item(ACT_READ, 0, 0, 1'b1, 16'hFFFF);
      queue_item(ACT_NONE, 63, 63, 1'b1, 16'hFFFF);

      // One-site torus: every neighbour is the site itself
      configure(1, 1, 0, THRESH8_RESET);
      queue_item(ACT_UPDATE, 0, 0, 1'b0, 16'h0000);
      queue_item(ACT_UPDATE, 0, 0, 1'b1, 16'hFFFF);
      queue_item(ACT_UPDATE, 0, 0, 1'b0, 16'h0000);
      queue_item(ACT_LOAD, 1, 0, 1'b1, 16'h0000);
      queue_item(ACT_READ, 0, 63, 1'b0, 16'h0000);
      queue_item(ACT_UPDATE, 63, 63, 1'b1, 16'hFFFF);

      // Zero sizes flag everything
      configure(0, 0, 65535, 65535);
      queue_item(ACT_LOAD, 0, 0, 1'b1, 16'h0000);
      queue_item(ACT_READ, 0, 0, 1'b0, 16'h0000);
      queue_item(ACT_UPDATE, 0, 0, 1'b0, 16'h0000);

      // Oversized registers saturate to the full lattice
      configure(127, 100, THRESH4_RESET, THRESH8_RESET);
      queue_item(ACT_READ, 63, 63, 1'b0, 16'h0000);
      queue_item(ACT_LOAD, 63, 0, 1'b1, 16'h0000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(2, 2, 0, 65535);
            1: configure(3, 5, 65535, 0);
            2: configure(8, 8, $urandom_range(0, 65535), $urandom_range(0, 65535));
            3: configure(1, 7, THRESH4_RESET, THRESH8_RESET);
            4: configure(64, 64, $urandom_range(0, 65535), $urandom_range(0, 65535));
            5: configure(5, 1, 32768, 16384);
            6: configure(16, 4, $urandom_range(0, 65535), $urandom_range(0, 65535));
            7: configure(127, 2, $urandom_range(0, 65535), $urandom_range(0, 65535));
            default: configure(7, 3, $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         if (phase < 3) begin
            send_idle_pct = 35;
            recv_idle_pct = 48;
         end else if (phase < 6) begin
            send_idle_pct = 48;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold the sender mid-phase until every result is back
            if (phase == 4 && i == PHASE_ITEMS / 2)
               wait_idle();
            queue_random_item();
         end
      end

      wait_idle();
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(apply_site_item(item_on_port));
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item_on_port = pending_items.pop_front();
               req_valid           <= 1'b1;
               req_action          <= item_on_port.action;
               req_col             <= item_on_port.col;
               req_row             <= item_on_port.row;
               req_pixel_in        <= item_on_port.pixel_in;
               req_random_fraction <= item_on_port.fraction;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      site_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               if (count_failure())
                  $display("result %0d arrived with no item outstanding", result_count);
            end else begin
               want = expected_results.pop_front();
               if (rsp_pixel_out !== want.pixel_out || rsp_neighbour_count !== want.count
                   || rsp_flipped !== want.flipped || rsp_coord_error !== want.coord_error) begin
                  if (count_failure())
                     $display({"result %0d: expected pixel %0b count %0d flipped %0b error %0b,",
                               " got pixel %0b count %0d flipped %0b error %0b"},
                              result_count, want.pixel_out, want.count, want.flipped,
                              want.coord_error, rsp_pixel_out, rsp_neighbour_count,
                              rsp_flipped, rsp_coord_error);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
